FILE: design/u16u8_pkg.sv
package u16u8_pkg;

  // default number of entries between the front and the back
  localparam int unsigned QueueDepthDefault = 2;

  // source formats selected by the mode register
  localparam logic ModeUtf16  = 1'b0;
  localparam logic ModeLatin1 = 1'b1;

  // surrogate ranges, upper six bits of the code unit
  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag  = 6'b110111;
  localparam logic [20:0] SuppBase   = 21'h10000;

  // sequence length minus one
  localparam logic [1:0] LenOne   = 2'd0;
  localparam logic [1:0] LenTwo   = 2'd1;
  localparam logic [1:0] LenThree = 2'd2;
  localparam logic [1:0] LenFour  = 2'd3;

  // one queue entry: an optional flushed high surrogate, then an optional code point
  typedef struct packed {
    logic        flush_v;
    logic [9:0]  flush_bits;
    logic        main_v;
    logic [20:0] main_cp;
    logic [1:0]  main_lm1;
    logic        str_end;
  } entry_t;

  // number of utf-8 bytes minus one for a code point
  function automatic logic [1:0] cp_len_m1(logic [20:0] cp);
    logic [1:0] lm1;
    if (cp[20:7] == '0) begin
      lm1 = LenOne;
    end else if (cp[20:11] == '0) begin
      lm1 = LenTwo;
    end else if (cp[20:16] == '0) begin
      lm1 = LenThree;
    end else begin
      lm1 = LenFour;
    end
    return lm1;
  endfunction

  // byte number idx of the utf-8 sequence of cp
  function automatic logic [7:0] enc_byte(logic [20:0] cp, logic [1:0] lm1, logic [1:0] idx);
    logic [7:0] b;
    logic [1:0] rem;
    rem = lm1 - idx;
    if (idx == 2'd0) begin
      case (lm1)
        LenOne:   b = {1'b0, cp[6:0]};
        LenTwo:   b = {3'b110, cp[10:6]};
        LenThree: b = {4'b1110, cp[15:12]};
        default:  b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (rem)
        2'd0:    b = {2'b10, cp[5:0]};
        2'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

FILE: design/u16u8_front.sv
module u16u8_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_data_i,
  input  logic                  push_i,
  input  logic [15:0]           code_unit_i,
  input  logic                  string_end_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output u16u8_pkg::entry_t     q_entry_o
);
  import u16u8_pkg::*;

  logic       mode_q, mode_d;
  logic       held_q, held_d;
  logic [9:0] held_bits_q, held_bits_d;
  logic       accept;
  logic       is_high, is_low;
  entry_t     entry;

  assign accept  = push_i && !q_full_i;
  assign is_high = (code_unit_i[15:10] == HighSurrTag);
  assign is_low  = (code_unit_i[15:10] == LowSurrTag);

  // mode register
  always_comb begin
    mode_d = mode_q;
    if (cfg_valid_i) begin
      mode_d = cfg_data_i;
    end
  end

  // classify the incoming word
  always_comb begin
    held_d      = held_q;
    held_bits_d = held_bits_q;
    entry       = '0;
    entry.str_end = string_end_i;
    if (mode_q == ModeLatin1) begin
      entry.flush_v    = held_q;
      entry.flush_bits = held_bits_q;
      entry.main_v     = 1'b1;
      entry.main_cp    = {13'b0, code_unit_i[7:0]};
      held_d           = 1'b0;
      held_bits_d      = '0;
    end else if (held_q && is_low) begin
      entry.main_v  = 1'b1;
      entry.main_cp = SuppBase + {1'b0, held_bits_q, code_unit_i[9:0]};
      held_d        = 1'b0;
      held_bits_d   = '0;
    end else begin
      entry.flush_v    = held_q;
      entry.flush_bits = held_bits_q;
      if (is_high && !string_end_i) begin
        held_d      = 1'b1;
        held_bits_d = code_unit_i[9:0];
      end else begin
        entry.main_v  = 1'b1;
        entry.main_cp = {5'b0, code_unit_i};
        held_d        = 1'b0;
        held_bits_d   = '0;
      end
    end
    entry.main_lm1 = cp_len_m1(entry.main_cp);
  end

  assign q_entry_o = entry;
  assign q_push_o  = accept && (entry.flush_v || entry.main_v);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeUtf16;
      held_q      <= 1'b0;
      held_bits_q <= '0;
    end else begin
      mode_q <= mode_d;
      if (accept) begin
        held_q      <= held_d;
        held_bits_q <= held_bits_d;
      end
    end
  end

  // a latin-1 word always leaves nothing held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_q == ModeLatin1) |=> !held_q)
    else $error("surrogate still held after latin-1 word");

endmodule

FILE: design/u16u8_queue.sv
module u16u8_queue #(
  parameter int unsigned Depth = u16u8_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u16u8_pkg::entry_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output u16u8_pkg::entry_t head_o
);
  import u16u8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o)
    else $error("queue read while empty");

endmodule

FILE: design/u16u8_back.sv
module u16u8_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  u16u8_pkg::entry_t head_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        utf8_byte_o,
  output logic              run_last_o,
  output logic              string_last_o
);
  import u16u8_pkg::*;

  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        run_last_q, str_last_q;
  logic        main_phase_q, main_phase_d;
  logic [1:0]  idx_q, idx_d;
  logic        advance, in_flush, phase_last, entry_last;
  logic [1:0]  len_m1;
  logic [20:0] cp;

  assign advance = !out_valid_q || pop_i;

  // pick the sequence being serialized
  assign in_flush   = head_i.flush_v && !main_phase_q;
  assign len_m1     = in_flush ? LenThree : head_i.main_lm1;
  assign cp         = in_flush ? {5'b0, HighSurrTag, head_i.flush_bits} : head_i.main_cp;
  assign phase_last = (idx_q == len_m1);
  assign entry_last = phase_last && (!in_flush || !head_i.main_v);
  assign q_pop_o    = advance && head_valid_i && entry_last;

  // byte position
  always_comb begin
    idx_d        = idx_q;
    main_phase_d = main_phase_q;
    if (advance && head_valid_i) begin
      if (phase_last) begin
        idx_d        = '0;
        main_phase_d = !entry_last;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      main_phase_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      main_phase_q <= main_phase_d;
      if (advance) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (advance && head_valid_i) begin
      byte_q     <= enc_byte(cp, len_m1, idx_q);
      run_last_q <= entry_last;
      str_last_q <= entry_last && head_i.str_end;
    end
  end

  assign empty_o       = !out_valid_q;
  assign utf8_byte_o   = byte_q;
  assign run_last_o    = run_last_q;
  assign string_last_o = str_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= len_m1)
    else $error("byte index past end of sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i && main_phase_q |-> head_i.flush_v && head_i.main_v)
    else $error("second phase without two sequences");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> head_i.flush_v || head_i.main_v)
    else $error("queue entry carries no bytes");

endmodule

FILE: design/utf16be_to_utf8_transcoder_core.sv
// UTF-16BE / Latin-1 to UTF-8 transcoder.
// Input side: a word (code_unit_i, string_end_i) is taken when push is high and
// full is low. Output side: one UTF-8 byte sits on utf8_byte_o while empty is low
// and leaves when pop is high; run_last_o marks the last byte of an input word,
// string_last_o the last byte of a word that had string_end_i set.
// Mode register: cfg_data_i is written when cfg_valid_i is high (cfg_ready_o is
// always high); 0 selects UTF-16 code units, 1 Latin-1 bytes. Write it only idle.
// A taken word is written into the queue, and its bytes are then registered into
// the output stage one by one.
// Throughput: the output stage moves one byte per cycle unless pop low stalls it;
// a word yields 1 to 4 bytes, up to 6 when a held high surrogate is flushed
// first, 0 when a high surrogate is held. A classifier front end feeds a small
// queue (QueueDepth entries) that a byte serializer drains.
// Reset: UTF-16 mode, nothing held, queue and output empty.
// Stall: with pop low the output byte holds, the serializer stops, the queue
// fills and full rises; push is taken again once an entry drains.
module utf16be_to_utf8_transcoder_core #(
  parameter int unsigned QueueDepth = u16u8_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit_i,
  input  logic        string_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  utf8_byte_o,
  output logic        run_last_o,
  output logic        string_last_o
);
  import u16u8_pkg::*;

  logic   q_push, q_full, q_pop, head_valid;
  entry_t q_entry, head;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  // classifier and surrogate holding
  u16u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .code_unit_i  (code_unit_i),
    .string_end_i (string_end_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_entry)
  );

  // decoupling queue
  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .wdata_i      (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // byte serializer and output register
  u16u8_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .q_pop_o       (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .utf8_byte_o   (utf8_byte_o),
    .run_last_o    (run_last_o),
    .string_last_o (string_last_o)
  );

endmodule

FILE: bench/utf16be_to_utf8_transcoder_core_tb.sv
module utf16be_to_utf8_transcoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u16u8_pkg::ModeUtf16;
  import u16u8_pkg::ModeLatin1;

  localparam int SettleCycles = 8;
  localparam int DrainCycles  = 40;
  localparam int HoldCycles   = 220;
  localparam int CycleLimit   = 300000;

  // one entry of the stimulus backlog: a data word or a mode write
  typedef struct {
    logic        is_cfg;
    logic        mode;
    logic [15:0] unit;
    logic        str_end;
  } unit_item_t;

  // one expected output byte
  typedef struct {
    logic [7:0] data_byte;
    logic       run_last;
    logic       string_last;
  } utf8_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] code_unit_i = '0;
  logic        string_end_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  utf8_byte_o;
  logic        run_last_o;
  logic        string_last_o;

  unit_item_t unit_backlog[$];
  utf8_out_t  utf8_expect[$];
  int         hold_marks[$];
  int         words_queued = 0;
  int         words_taken = 0;
  int         errors = 0;
  int         cycles = 0;

  // predictor state
  logic       mode_q = ModeUtf16;
  logic       held_v = 1'b0;
  logic [9:0] held_bits = '0;

  utf16be_to_utf8_transcoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .code_unit_i   (code_unit_i),
    .string_end_i  (string_end_i),
    .empty         (empty),
    .pop           (pop),
    .utf8_byte_o   (utf8_byte_o),
    .run_last_o    (run_last_o),
    .string_last_o (string_last_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    utf8_out_t o;
    o.data_byte   = b;
    o.run_last    = 1'b0;
    o.string_last = 1'b0;
    utf8_expect.insert(utf8_expect.size(), o);
  endtask

  // utf-8 bytes of one code point
  task automatic encode_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_byte({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      put_byte(8'hc0 | cp[10:6]);
      put_byte(8'h80 | cp[5:0]);
    end else if (cp < 21'h10000) begin
      put_byte(8'he0 | cp[15:12]);
      put_byte(8'h80 | cp[11:6]);
      put_byte(8'h80 | cp[5:0]);
    end else begin
      put_byte(8'hf0 | cp[20:18]);
      put_byte(8'h80 | cp[17:12]);
      put_byte(8'h80 | cp[11:6]);
      put_byte(8'h80 | cp[5:0]);
    end
  endtask

  // a pending high surrogate goes out alone as three bytes
  task automatic flush_surrogate();
    if (held_v) begin
      encode_point(21'hd800 | held_bits);
      held_v = 1'b0;
      held_bits = '0;
    end
  endtask

  // expected bytes for one accepted word
  task automatic transcode_unit(input logic [15:0] cu, input logic se);
    int n0;
    logic paired;
    n0 = utf8_expect.size();
    paired = 1'b0;
    if (mode_q == ModeLatin1) begin
      flush_surrogate();
      encode_point({13'd0, cu[7:0]});
    end else begin
      if (held_v) begin
        if (cu >= 16'hdc00 && cu <= 16'hdfff) begin
          encode_point(21'h10000 + {1'b0, held_bits, cu[9:0]});
          held_v = 1'b0;
          held_bits = '0;
          paired = 1'b1;
        end else begin
          flush_surrogate();
        end
      end
      if (!paired) begin
        if (cu >= 16'hd800 && cu <= 16'hdbff && !se) begin
          held_v = 1'b1;
          held_bits = cu[9:0];
        end else begin
          encode_point({5'd0, cu});
        end
      end
    end
    // mark the last byte of this word
    if (utf8_expect.size() > n0) begin
      utf8_expect[utf8_expect.size() - 1].run_last    = 1'b1;
      utf8_expect[utf8_expect.size() - 1].string_last = se;
    end
  endtask

  // driver: words and mode writes from the backlog
  always @(posedge clk_i) begin : send_proc
    unit_item_t w;
    logic nxt_push;
    logic nxt_cfg;
    int send_wait;
    int settle;
    int quiet;
    if (!rst_ni) begin
      push <= 1'b0;
      cfg_valid_i <= 1'b0;
      send_wait = 0;
      settle = 0;
      quiet = 0;
    end else begin
      if (push && !full) begin
        transcode_unit(code_unit_i, string_end_i);
        words_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q = cfg_data_i;
      end
      if (utf8_expect.size() == 0 && !push && !cfg_valid_i) begin
        settle++;
      end else begin
        settle = 0;
      end
      nxt_push = push && full;
      nxt_cfg = cfg_valid_i && !cfg_ready_o;
      if (!nxt_push && !nxt_cfg) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (unit_backlog.size() > 0) begin
          if (unit_backlog[0].is_cfg) begin
            // mode writes only once the block has gone quiet
            if (settle >= SettleCycles) begin
              w = unit_backlog.pop_front();
              cfg_data_i <= w.mode;
              nxt_cfg = 1'b1;
            end
          end else begin
            w = unit_backlog.pop_front();
            code_unit_i <= w.unit;
            string_end_i <= w.str_end;
            nxt_push = 1'b1;
            if (quiet > 0) begin
              quiet--;
              send_wait = 0;
            end else begin
              send_wait = pick_gap();
              if ($urandom_range(0, 29) == 0) quiet = $urandom_range(10, 40);
            end
          end
        end
      end
      push <= nxt_push;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // monitor: pops output bytes and checks them against the oldest expectation
  always @(posedge clk_i) begin : take_proc
    utf8_out_t e;
    int take_wait;
    int quiet;
    if (!rst_ni) begin
      pop <= 1'b0;
      take_wait = 0;
      quiet = 0;
    end else begin
      if (pop && !empty) begin
        if (utf8_expect.size() == 0) begin
          $display("%0t: unexpected byte %h run_last %b string_last %b", $time,
                   utf8_byte_o, run_last_o, string_last_o);
          errors++;
        end else begin
          e = utf8_expect.pop_front();
          if (e.data_byte !== utf8_byte_o || e.run_last !== run_last_o ||
              e.string_last !== string_last_o) begin
            $display("%0t: mismatch, expected byte %h run_last %b string_last %b, got %h %b %b",
                     $time, e.data_byte, e.run_last, e.string_last,
                     utf8_byte_o, run_last_o, string_last_o);
            errors++;
          end
        end
        if (quiet > 0) begin
          quiet--;
          take_wait = 0;
        end else begin
          take_wait = pick_gap();
          if ($urandom_range(0, 29) == 0) quiet = $urandom_range(10, 40);
        end
      end else if (!pop && take_wait > 0) begin
        take_wait--;
      end
      // long hold-off so the block backs up and raises full
      if (hold_marks.size() > 0 && words_taken >= hold_marks[0]) begin
        void'(hold_marks.pop_front());
        take_wait = HoldCycles;
      end
      pop <= (take_wait == 0);
    end
  end

  task automatic add_word(input logic [15:0] unit, input logic se);
    unit_item_t w;
    w.is_cfg = 1'b0;
    w.mode = 1'b0;
    w.unit = unit;
    w.str_end = se;
    unit_backlog.insert(unit_backlog.size(), w);
    words_queued++;
  endtask

  task automatic add_mode(input logic m);
    unit_item_t w;
    w.is_cfg = 1'b1;
    w.mode = m;
    w.unit = '0;
    w.str_end = 1'b0;
    unit_backlog.insert(unit_backlog.size(), w);
  endtask

  // mostly well-formed utf-16 text, with lone surrogates and raw noise mixed in
  task automatic add_utf16_run(input int n);
    int cnt;
    int r;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        add_word(16'($urandom_range(0, 16'h7f)), $urandom_range(0, 5) == 0);
      end else if (r < 35) begin
        add_word(16'($urandom_range(16'h80, 16'h7ff)), $urandom_range(0, 5) == 0);
      end else if (r < 50) begin
        if ($urandom_range(0, 1) != 0) begin
          add_word(16'($urandom_range(16'h800, 16'hd7ff)), $urandom_range(0, 5) == 0);
        end else begin
          add_word(16'($urandom_range(16'he000, 16'hffff)), $urandom_range(0, 5) == 0);
        end
      end else if (r < 80) begin
        add_word(16'($urandom_range(16'hd800, 16'hdbff)), 1'b0);
        add_word(16'($urandom_range(16'hdc00, 16'hdfff)), $urandom_range(0, 5) == 0);
        cnt++;
      end else if (r < 87) begin
        add_word(16'($urandom_range(16'hd800, 16'hdbff)), $urandom_range(0, 3) == 0);
      end else if (r < 93) begin
        add_word(16'($urandom_range(16'hdc00, 16'hdfff)), $urandom_range(0, 3) == 0);
      end else begin
        add_word(16'($urandom_range(0, 16'hffff)), 1'($urandom_range(0, 1)));
      end
      cnt++;
    end
  endtask

  // latin-1 bytes with junk in the upper half
  task automatic add_latin1_run(input int n);
    for (int i = 0; i < n; i++) begin
      add_word(16'($urandom_range(0, 16'hffff)), $urandom_range(0, 5) == 0);
    end
  endtask

  // stimulus and end of run
  initial begin
    // directed: utf-16 extremes and surrogate handling
    add_mode(ModeUtf16);
    add_word(16'h0000, 1'b0);
    add_word(16'h007f, 1'b0);
    add_word(16'h0080, 1'b0);
    add_word(16'h07ff, 1'b0);
    add_word(16'h0800, 1'b0);
    add_word(16'hffff, 1'b1);
    // lowest and highest surrogate pairs
    add_word(16'hd800, 1'b0);
    add_word(16'hdc00, 1'b0);
    add_word(16'hdbff, 1'b0);
    add_word(16'hdfff, 1'b1);
    // high surrogate at string end goes out at once
    add_word(16'hd912, 1'b1);
    // held surrogate followed by plain text
    add_word(16'hdabc, 1'b0);
    add_word(16'h0041, 1'b0);
    // held surrogate followed by another high one, which is held in turn
    add_word(16'hd801, 1'b0);
    add_word(16'hdbfe, 1'b0);
    add_word(16'h1234, 1'b0);
    // held surrogate followed by a high one at string end
    add_word(16'hd805, 1'b0);
    add_word(16'hd906, 1'b1);
    // lone low surrogate
    add_word(16'hdc55, 1'b0);
    // surrogate still held across the switch to latin-1
    add_word(16'hd8aa, 1'b0);
    add_mode(ModeLatin1);
    add_word(16'hab41, 1'b0);
    add_word(16'h00ff, 1'b1);
    add_word(16'hff80, 1'b0);
    add_word(16'hd800, 1'b1);

    // random phases, alternating modes
    add_mode(ModeUtf16);
    add_utf16_run(50);
    add_mode(ModeLatin1);
    add_latin1_run(30);
    add_mode(ModeUtf16);
    hold_marks.insert(hold_marks.size(), words_queued + 10);
    hold_marks.insert(hold_marks.size(), words_queued + 60);
    add_utf16_run(90);
    add_mode(ModeLatin1);
    add_latin1_run(20);
    add_mode(ModeUtf16);
    add_utf16_run(20);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (unit_backlog.size() != 0 || push || cfg_valid_i || utf8_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
